// File: sv/dbdl_pkg.sv
package dbdl_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned LABEL_W = 16;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [DELAY_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic signed [LABEL_W-1:0] LABEL_RESET = 16'sd1;
	localparam logic signed [LABEL_W-1:0] LABEL_MAX   = 16'sh7fff;
	localparam logic signed [LABEL_W-1:0] LABEL_MIN   = 16'sh8000;

	// debounced levels of both buttons after one sample
	typedef struct packed {
		logic a;
		logic b;
	} deb_t;

endpackage

// File: sv/dbdl_filter.sv
module dbdl_filter
	import dbdl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  logic               raw,
	input  logic [TIME_W-1:0]  now,
	input  logic [DELAY_W-1:0] delay,
	output logic               stable_nxt
);

	logic              last_q;
	logic              stable_q;
	logic [TIME_W-1:0] chg_time_q;
	logic [TIME_W-1:0] chg_time;
	logic [TIME_W-1:0] elapsed;

	// a raw change restarts the hold time on this very sample
	assign chg_time   = (raw != last_q) ? now : chg_time_q;
	assign elapsed    = now - chg_time;
	assign stable_nxt = (elapsed > {{(TIME_W-DELAY_W){1'b0}}, delay}) ? raw : stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= 1'b0;
			stable_q   <= 1'b0;
			chg_time_q <= '0;
		end else if (upd) begin
			last_q     <= raw;
			stable_q   <= stable_nxt;
			chg_time_q <= chg_time;
		end
	end

endmodule

// File: sv/dbdl_label.sv
module dbdl_label
	import dbdl_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  deb_t                      deb,
	output logic                      chord,
	output logic signed [LABEL_W-1:0] label_nxt,
	output logic signed [LABEL_W-1:0] label_cur
);

	logic                      prior_a_q;
	logic                      prior_b_q;
	logic                      prior_chord_q;
	logic signed [LABEL_W-1:0] label_q;
	logic                      both;
	logic                      new_a;
	logic                      new_b;

	assign both      = deb.a && deb.b;
	assign chord     = both && !prior_chord_q;
	assign new_a     = deb.a && !prior_a_q;
	assign new_b     = deb.b && !prior_b_q;
	assign label_cur = label_q;

	// label only moves on a lone press, saturating at both ends
	always_comb begin
		label_nxt = label_q;
		if (!both) begin
			if (new_a && !deb.b) begin
				if (label_q != LABEL_MAX)
					label_nxt = label_q + 16'sd1;
			end else if (new_b && !deb.a) begin
				if (label_q != LABEL_MIN)
					label_nxt = label_q - 16'sd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_a_q     <= 1'b0;
			prior_b_q     <= 1'b0;
			prior_chord_q <= 1'b0;
			label_q       <= LABEL_RESET;
		end else if (upd) begin
			// press history frozen while chorded
			if (!both) begin
				prior_a_q <= deb.a;
				prior_b_q <= deb.b;
			end
			prior_chord_q <= both;
			label_q       <= label_nxt;
		end
	end

endmodule

// File: sv/dual_button_debounce_label_counter.sv
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: raw_pressed_a, raw_pressed_b, now_ms
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: stable_a, stable_b, chord_event,
//           |     |                              |        label_value
// cfg       | in  | cfg_we                       | cfg_wdata: debounce_ms
//
// one request per clock while m_axis is not stalled; each request passes from s_axis to m_axis
// through the input register, then filter and label update into the result register
// reset clears both stages, debounce state, label to 1 and debounce_ms to 50
// a stalled m_axis holds both stages; s_axis_tready drops only while the result waits
module dual_button_debounce_label_counter
	import dbdl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] raw_pressed_a, [1] raw_pressed_b, [33:2] now_ms, [39:34] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] stable_a, [1] stable_b, [2] chord_event, [18:3] label_value, [23:19] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [DELAY_W-1:0]    cfg_wdata
);

	logic [DELAY_W-1:0]        debounce_q;
	logic                      valid_s1;
	logic                      raw_a_s1;
	logic                      raw_b_s1;
	logic [TIME_W-1:0]         now_s1;
	logic                      valid_s2;
	logic [OUT_DATA_W-1:0]     data_s2;
	logic                      adv;
	logic                      upd;
	deb_t                      deb;
	logic                      chord;
	logic signed [LABEL_W-1:0] label_nxt;
	logic signed [LABEL_W-1:0] label_cur;

	assign adv           = !valid_s2 || m_axis_tready;
	assign upd           = valid_s1 && adv;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			debounce_q <= DEBOUNCE_RESET;
		else if (cfg_we)
			debounce_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_axis_tvalid) begin
			raw_a_s1 <= s_axis_tdata[0];
			raw_b_s1 <= s_axis_tdata[1];
			now_s1   <= s_axis_tdata[TIME_W+1:2];
		end
		if (upd)
			data_s2 <= {{(OUT_DATA_W-LABEL_W-3){1'b0}}, label_nxt, chord, deb.b, deb.a};
	end

	dbdl_filter u_filt_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.raw        (raw_a_s1),
		.now        (now_s1),
		.delay      (debounce_q),
		.stable_nxt (deb.a)
	);

	dbdl_filter u_filt_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.raw        (raw_b_s1),
		.now        (now_s1),
		.delay      (debounce_q),
		.stable_nxt (deb.b)
	);

	dbdl_label u_label (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.deb       (deb),
		.chord     (chord),
		.label_nxt (label_nxt),
		.label_cur (label_cur)
	);

	// a chord result always shows both buttons down
	a_chord_both: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("chord without both buttons debounced");

	// label moves by at most one per request
	a_label_step: assert property (@(posedge clk) disable iff (!arst_n)
		upd |-> ((label_nxt == label_cur) || (label_nxt == label_cur + 16'sd1) ||
			(label_nxt == label_cur - 16'sd1)))
		else $error("label stepped by more than one");

	// a chord request never changes the label
	a_chord_label: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && chord) |-> (label_nxt == label_cur))
		else $error("label changed on chord");

	// a waiting result keeps the first stage and the label frozen
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |=> ($stable(valid_s1) && $stable(label_cur)))
		else $error("pipeline moved while stalled");

endmodule

// File: verif/dual_button_debounce_label_counter_tb.sv
`timescale 1ns / 100ps

module dual_button_debounce_label_counter_tb;
	import dbdl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	// s_axis_tdata layout, lowest bit last
	typedef struct packed {
		logic [IN_DATA_W-TIME_W-3:0] pad;
		logic [TIME_W-1:0]           now_ms;
		logic                        raw_b;
		logic                        raw_a;
	} sample_t;

	// m_axis_tdata layout, lowest bit last
	typedef struct packed {
		logic [OUT_DATA_W-LABEL_W-4:0] pad;
		logic signed [LABEL_W-1:0]     label;
		logic                          chord;
		logic                          stable_b;
		logic                          stable_a;
	} status_t;

	typedef enum {RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	class label_scoreboard;
		logic [DELAY_W-1:0]        delay_ms;
		logic                      last_a, last_b, deb_a, deb_b;
		logic                      prior_a, prior_b, prior_both;
		logic [TIME_W-1:0]         changed_a, changed_b;
		logic signed [LABEL_W-1:0] label;
		status_t                   status_q[$];
		int                        errors;

		function new();
			delay_ms = DEBOUNCE_RESET;
			last_a = 1'b0;
			last_b = 1'b0;
			deb_a = 1'b0;
			deb_b = 1'b0;
			prior_a = 1'b0;
			prior_b = 1'b0;
			prior_both = 1'b0;
			changed_a = '0;
			changed_b = '0;
			label = LABEL_RESET;
			errors = 0;
		endfunction

		function void filter(input logic raw, input logic [TIME_W-1:0] now,
			inout logic last, inout logic [TIME_W-1:0] changed, inout logic stable);
			logic [TIME_W-1:0] elapsed;
			if (raw != last)
				changed = now;
			// wrapping difference, so a step back in time reads as a long hold
			elapsed = now - changed;
			if (elapsed > TIME_W'(delay_ms))
				stable = raw;
			last = raw;
		endfunction

		function void note_sample(input sample_t s);
			status_t res;
			logic    both;
			filter(s.raw_a, s.now_ms, last_a, changed_a, deb_a);
			filter(s.raw_b, s.now_ms, last_b, changed_b, deb_b);
			both = deb_a & deb_b;
			res = '0;
			if (both && !prior_both) begin
				res.chord = 1'b1;
			end else if (!both) begin
				if (deb_a && !prior_a && !deb_b) begin
					if (label != LABEL_MAX)
						label = label + 16'sd1;
				end else if (deb_b && !prior_b && !deb_a) begin
					if (label != LABEL_MIN)
						label = label - 16'sd1;
				end
				// press history frozen while chorded
				prior_a = deb_a;
				prior_b = deb_b;
			end
			prior_both = both;
			res.stable_a = deb_a;
			res.stable_b = deb_b;
			res.label = label;
			status_q.push_back(res);
		endfunction

		function void check_result(input status_t got);
			status_t want;
			if (status_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result a=%0b b=%0b chord=%0b label=%0d",
						got.stable_a, got.stable_b, got.chord, got.label);
				return;
			end
			want = status_q.pop_front();
			if (got.stable_a !== want.stable_a || got.stable_b !== want.stable_b ||
				got.chord !== want.chord || got.label !== want.label) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected a=%0b b=%0b chord=%0b label=%0d, got a=%0b b=%0b chord=%0b label=%0d",
						want.stable_a, want.stable_b, want.chord, want.label,
						got.stable_a, got.stable_b, got.chord, got.label);
			end
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [DELAY_W-1:0]    cfg_wdata = '0;

	label_scoreboard   sb;
	logic [TIME_W-1:0] t_now = '0;
	logic              hold_a = 1'b0, hold_b = 1'b0;
	bit                full_rate = 1'b0;
	int                burst_left = 0;
	int unsigned       cycle_count = 0;
	int                rx_cycle = 0;
	rx_mode_t          rx_mode = RX_STEADY;

	dual_button_debounce_label_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver stalls, switching among steady, coin-flip, periodic and sparse patterns; always ready at full rate
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (full_rate) begin
			m_axis_tready <= 1'b1;
		end else begin
			case (rx_mode)
				RX_STEADY:   m_axis_tready <= 1'b1;
				RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
				RX_PERIODIC: m_axis_tready <= (rx_cycle % 7) < 4;
				default:     m_axis_tready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(status_t'(m_axis_tdata));

	task automatic send(input logic a, input logic b, input logic [TIME_W-1:0] now);
		sample_t s;
		s = '0;
		s.raw_a = a;
		s.raw_b = b;
		s.now_ms = now;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_delay(input logic [DELAY_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		sb.delay_ms = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly a forward-running timeline with held buttons, some noise samples
	task automatic random_run(input int n, input int d);
		int unsigned step;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
			end else begin
				case ($urandom_range(0, 2))
					0: step = $urandom_range(0, 3);
					1: step = (d == 0) ? $urandom_range(0, 2) : d - 1 + $urandom_range(0, 2);
					default: step = $urandom_range(d, 2 * d + 8);
				endcase
				t_now += step;
				if ($urandom_range(0, 4) == 0)
					hold_a = ~hold_a;
				if ($urandom_range(0, 4) == 0)
					hold_b = ~hold_b;
				send(hold_a, hold_b, t_now);
			end
			pace();
		end
	endtask

	// one lone press and release, needs zero debounce delay
	task automatic tap(input logic on_b);
		send(~on_b, on_b, t_now);
		send(~on_b, on_b, t_now + 1);
		send(1'b0, 1'b0, t_now + 2);
		send(1'b0, 1'b0, t_now + 3);
		t_now += 4;
	endtask

	initial begin
		int d;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset delay of 50
		send(1'b0, 1'b0, 32'd0);
		send(1'b1, 1'b0, 32'd100);
		send(1'b1, 1'b0, 32'd150);
		send(1'b1, 1'b0, 32'd151);
		send(1'b0, 1'b0, 32'd152);
		send(1'b0, 1'b0, 32'd203);
		send(1'b0, 1'b1, 32'd204);
		send(1'b0, 1'b1, 32'd255);
		send(1'b1, 1'b1, 32'd256);
		send(1'b1, 1'b1, 32'd307);
		// release a while b stays held: no label change
		send(1'b0, 1'b1, 32'd308);
		send(1'b0, 1'b1, 32'd359);
		send(1'b0, 1'b0, 32'd360);
		send(1'b0, 1'b0, 32'd411);
		// a, then chord, then release a: b counts as a fresh press
		send(1'b1, 1'b0, 32'd412);
		send(1'b1, 1'b0, 32'd463);
		send(1'b1, 1'b1, 32'd464);
		send(1'b1, 1'b1, 32'd515);
		send(1'b0, 1'b1, 32'd516);
		send(1'b0, 1'b1, 32'd567);
		// timestamp wrap and a step back in time
		send(1'b1, 1'b1, 32'hffff_fff0);
		send(1'b1, 1'b1, 32'h0000_0030);
		send(1'b0, 1'b0, 32'd1000);
		send(1'b0, 1'b0, 32'd999);
		send(1'b1, 1'b1, 32'hffff_ffff);

		write_delay('0);
		send(1'b0, 1'b0, 32'd7);
		send(1'b1, 1'b0, 32'd7);
		send(1'b1, 1'b0, 32'd7);
		send(1'b1, 1'b0, 32'd8);
		random_run(75, 0);

		write_delay('1);
		send(1'b0, 1'b0, 32'h0001_0000);
		send(1'b1, 1'b1, 32'h0001_0001);
		send(1'b1, 1'b1, 32'h0002_0000);
		send(1'b1, 1'b1, 32'h0002_0001);
		t_now = 32'h0002_0001;
		random_run(75, 65535);

		d = $urandom_range(1, 20);
		write_delay(DELAY_W'(d));
		random_run(75, d);

		d = $urandom_range(0, 65535);
		write_delay(DELAY_W'(d));
		random_run(75, d);

		write_delay(DEBOUNCE_RESET);
		random_run(75, 50);

		// lone taps up and down at full rate
		write_delay('0);
		full_rate = 1'b1;
		t_now += 1000;
		send(1'b0, 1'b0, t_now);
		send(1'b0, 1'b0, t_now + 1);
		send(1'b0, 1'b0, t_now + 2);
		t_now += 3;
		repeat (4) tap(1'b0);
		repeat (6) tap(1'b1);
		full_rate = 1'b0;

		drain();
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
